// File: sv/pcmmix_pkg.sv
// Shared types and constants of the PCM mixer core.
// Holds the request codes, the sequencer states and the pitch step table.
// No dependencies.
package pcmmix_pkg;

  // Width of one pitch step in 2.16 form, integer part up to 3
  localparam int STEP_W = 18;

  // Reciprocal of 127 for the sample scaling, exact for products below 2^15
  localparam logic [23:0] RECIP_127 = 24'd8454661;
  localparam int RECIP_SHIFT = 22;

  // First handle given out after the counter wraps
  localparam logic [15:0] HANDLE_FIRST = 16'd100;

  // Saturation limits of the mixed output
  localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAT_MIN = -16'sh8000;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_UPDATE = 3'd3,
    OP_QUERY  = 3'd4,
    OP_MIX    = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_END,
    ST_GAIN_SQ,
    ST_GAIN_MUL,
    ST_WRITE,
    ST_MIX_RD,
    ST_MIX_SRD,
    ST_MIX_MUL,
    ST_MIX_DIV,
    ST_MIX_ACC,
    ST_DONE
  } state_t;

  typedef logic [255:0][STEP_W-1:0] step_rom_t;

  // Truncating Q62 product
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Entry p is 65536 * 2^((p-128)/64), built from a bisected 2^(1/64)
  function automatic step_rom_t build_step_rom();
    step_rom_t rom;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    logic [63:0] cur;
    logic [63:0] sh;
    int idx;
    lo = 64'd1 << 62;
    hi = lo + (lo >> 6);
    while (hi - lo > 64'd1) begin
      mid = lo + ((hi - lo) >> 1);
      p = mid;
      for (int k = 0; k < 6; k++) begin
        p = q62_mul(p, p);
      end
      if (p <= (64'd2 << 62)) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    cur = 64'd1 << 62;
    for (int r = 0; r < 64; r++) begin
      for (int q = -2; q <= 1; q++) begin
        idx = 64 * q + r + 128;
        sh = cur >> (46 - q);
        rom[idx] = sh[STEP_W-1:0];
      end
      cur = q62_mul(cur, lo);
    end
    return rom;
  endfunction

  localparam step_rom_t STEP_ROM = build_step_rom();

endpackage

// File: sv/pcmmix_scale.sv
// Two-stage sample scaler: gain * (sample - 128) * 256 / 127, toward zero.
// Left and right share the sample. Uses pcmmix_pkg for the reciprocal.
module pcmmix_scale (
  input  logic               clk,
  input  logic [6:0]         gain_l,
  input  logic [6:0]         gain_r,
  input  logic [7:0]         smp,
  output logic signed [16:0] term_l,
  output logic signed [16:0] term_r
);
  import pcmmix_pkg::*;

  logic        neg1;
  logic [14:0] mag_l;
  logic [14:0] mag_r;
  logic        neg2;
  logic [15:0] quo_l;
  logic [15:0] quo_r;
  logic [7:0]  amp;
  logic [38:0] prod_l;
  logic [38:0] prod_r;

  // Take the distance from silence
  always_comb begin
    amp = (smp < 8'd128) ? (8'd128 - smp) : (smp - 8'd128);
  end

  // Stage one: gain times magnitude
  always_ff @(posedge clk) begin
    neg1  <= (smp < 8'd128);
    mag_l <= 15'(gain_l * amp);
    mag_r <= 15'(gain_r * amp);
  end

  // Stage two: divide by 127 through the reciprocal
  always_comb begin
    prod_l = 39'(mag_l) * 39'(RECIP_127);
    prod_r = 39'(mag_r) * 39'(RECIP_127);
  end

  always_ff @(posedge clk) begin
    neg2  <= neg1;
    quo_l <= prod_l[RECIP_SHIFT+15:RECIP_SHIFT];
    quo_r <= prod_r[RECIP_SHIFT+15:RECIP_SHIFT];
  end

  // Restore the sign
  assign term_l = neg2 ? -$signed({1'b0, quo_l}) : $signed({1'b0, quo_l});
  assign term_r = neg2 ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

// File: sv/multichannel_pcm_sound_mixer_core.sv
// Top level of the multichannel PCM mixer core.
// Depends on pcmmix_pkg and pcmmix_scale.
//
// Usage: one request enters on the s_axis group (op in tuser, the other
// fields in tdata); exactly one result leaves on the m_axis group.
// A load writes one byte of the sample store. A start claims the lowest
// free channel or else the one started earliest and returns a handle from
// 100. Stop, update and query look channels up by handle. A mix tick reads
// one sample per active channel, scales it by the channel gains, advances
// it by its pitch step and returns saturated left and right sums.
// Timing: requests are taken one at a time, the channel records are read
// from a memory with a registered read port. A load writes the store and
// finishes; start, stop, update and query scan every channel (read, then
// evaluate), a matched stop adds a write, and a start or matched update
// adds the gain square, gain multiply and write steps. A mix tick reads each
// channel and runs the multiply, divide and accumulate steps for each active one.
// A new request is taken as soon as the previous result sits in the output
// register; a stalled receiver holds the result and then the sequencer.
// Reset clears all channels and the handle counter; the sample store
// holds garbage until written, and no clearing pass is run.
module multichannel_pcm_sound_mixer_core #(
  parameter int CHANNELS         = 8,
  parameter int SAMPLE_ADDR_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // address[15:0], data_byte[23:16], length[39:24], volume[46:40],
  // separation[54:47], pitch[62:55], sound_id[70:63], single_instance[71],
  // game_tick[102:72], handle[118:103], zero pad[119]
  input  logic [119:0] s_axis_tdata,
  // op[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left_sample[15:0], right_sample[31:16], handle_out[47:32],
  // is_playing[48], zero pad[55:49]
  output logic [55:0]  m_axis_tdata
);
  import pcmmix_pkg::*;

  localparam int AW     = SAMPLE_ADDR_BITS;
  localparam int END_W  = ((AW > 16) ? AW : 16) + 1;
  localparam int POS_W  = END_W + 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ACC_W  = $clog2(CHANNELS) + 18;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [15:0]       fraction;
    logic [STEP_W-1:0] step;
    logic [END_W-1:0]  end_addr;
    logic [30:0]       start_tick;
    logic [15:0]       handle;
    logic [7:0]        sound_id;
    logic [6:0]        gain_l;
    logic [6:0]        gain_r;
  } rec_t;

  state_t state, state_next;

  // Latched request
  op_t         op_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic [15:0] len_q;
  logic [6:0]  vol_q;
  logic [7:0]  sep_q;
  logic [7:0]  pit_q;
  logic [7:0]  sid_q;
  logic        single_q;
  logic [30:0] tick_q;
  logic [15:0] hnd_q;

  // Memories and per-channel flags
  logic [7:0]    store_mem [2**AW];
  logic [7:0]    store_q;
  rec_t          chan_mem [CHANNELS];
  rec_t          rec_q;
  logic [CHANNELS-1:0] written;
  logic [CHANNELS-1:0] active;

  // Sequencer registers
  logic [CH_W-1:0] idx;
  logic            hit;
  logic [CH_W-1:0] hit_idx;
  rec_t            rec_hit;
  logic [30:0]     old_tick;
  logic [CH_W-1:0] old_idx;
  logic [16:0]     sq_l;
  logic [16:0]     sq_r;
  logic [6:0]      gain_l;
  logic [6:0]      gain_r;
  logic signed [ACC_W-1:0] acc_l;
  logic signed [ACC_W-1:0] acc_r;
  logic [15:0]     next_handle;
  logic [15:0]     hout;
  logic            playing;
  logic            m_valid;
  logic [55:0]     m_data;

  // Combinational helpers
  logic            in_fire;
  logic            out_free;
  logic            last;
  rec_t            rec_eff;
  logic            match;
  logic            store_we;
  logic            chan_we;
  logic [CH_W-1:0] chan_waddr;
  rec_t            chan_wdata;
  logic            idx_adv;
  logic            free_found;
  logic [CH_W-1:0] free_idx;
  logic [CH_W-1:0] slot;
  logic [AW+15:0]  addr_wide;
  logic [AW-1:0]   addr_m;
  logic [18:0]     acc_frac;
  logic [POS_W-1:0] pos_new;
  logic [8:0]      sep_a;
  logic [8:0]      sep_b;
  logic [23:0]     prod_l;
  logic [23:0]     prod_r;
  logic [15:0]     hnd_use;
  logic signed [16:0] term_l;
  logic signed [16:0] term_r;
  logic signed [15:0] sat_l;
  logic signed [15:0] sat_r;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_valid || m_axis_tready;
  assign last          = (idx == CH_W'(CHANNELS - 1));
  assign rec_eff       = written[idx] ? rec_q : '0;
  assign addr_wide     = {{AW{1'b0}}, addr_q};
  assign addr_m        = addr_wide[AW-1:0];
  assign acc_frac      = {3'd0, rec_eff.fraction} + {1'b0, rec_eff.step};
  assign pos_new       = rec_eff.position + POS_W'(acc_frac[18:16]);
  assign sep_a         = {1'b0, sep_q} + 9'd1;
  assign sep_b         = 9'd256 - {1'b0, sep_q};
  assign prod_l        = 24'(vol_q) * 24'(sq_l);
  assign prod_r        = 24'(vol_q) * 24'(sq_r);
  assign hnd_use       = (next_handle == 16'd0) ? HANDLE_FIRST : next_handle;

  // Lookup match for the channel under scan
  always_comb begin
    unique case (op_q)
      OP_START:            match = single_q && active[idx] && (rec_eff.sound_id == sid_q);
      OP_STOP:             match = (rec_eff.handle == hnd_q);
      OP_UPDATE, OP_QUERY: match = active[idx] && (rec_eff.handle == hnd_q);
      default:             match = 1'b0;
    endcase
  end

  // Lowest free channel, else the oldest one
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (!free_found && !active[i]) begin
        free_found = 1'b1;
        free_idx   = CH_W'(i);
      end
    end
    slot = free_found ? free_idx : old_idx;
  end

  // Clamp a gain difference into 0..127
  function automatic logic [6:0] clamp_gain(input logic [6:0] v, input logic [7:0] t);
    logic signed [8:0] g;
    g = $signed({2'b00, v}) - $signed({1'b0, t});
    if (g < 0) begin
      return 7'd0;
    end else if (g > 9'sd127) begin
      return 7'd127;
    end
    return g[6:0];
  endfunction

  pcmmix_scale u_scale (
    .clk    (clk),
    .gain_l (rec_eff.gain_l),
    .gain_r (rec_eff.gain_r),
    .smp    (store_q),
    .term_l (term_l),
    .term_r (term_r)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (s_axis_tuser)
            OP_LOAD:                               state_next = ST_LOAD;
            OP_START, OP_STOP, OP_UPDATE, OP_QUERY: state_next = ST_SCAN_RD;
            OP_MIX:                                state_next = ST_MIX_RD;
            default:                               state_next = ST_DONE;
          endcase
        end
      end
      ST_LOAD:    state_next = ST_DONE;
      ST_SCAN_RD: state_next = ST_SCAN_EV;
      ST_SCAN_EV: state_next = last ? ST_SCAN_END : ST_SCAN_RD;
      ST_SCAN_END: begin
        priority case (1'b1)
          op_q == OP_START:         state_next = ST_GAIN_SQ;
          op_q == OP_UPDATE && hit: state_next = ST_GAIN_SQ;
          op_q == OP_STOP && hit:   state_next = ST_WRITE;
          default:                  state_next = ST_DONE;
        endcase
      end
      ST_GAIN_SQ:  state_next = ST_GAIN_MUL;
      ST_GAIN_MUL: state_next = ST_WRITE;
      ST_WRITE:    state_next = ST_DONE;
      ST_MIX_RD:   state_next = ST_MIX_SRD;
      ST_MIX_SRD: begin
        if (active[idx]) begin
          state_next = ST_MIX_MUL;
        end else begin
          state_next = last ? ST_DONE : ST_MIX_RD;
        end
      end
      ST_MIX_MUL: state_next = ST_MIX_DIV;
      ST_MIX_DIV: state_next = ST_MIX_ACC;
      ST_MIX_ACC: state_next = last ? ST_DONE : ST_MIX_RD;
      ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Per-state controls and write-back record
  always_comb begin
    store_we   = 1'b0;
    chan_we    = 1'b0;
    chan_waddr = idx;
    chan_wdata = rec_eff;
    idx_adv    = 1'b0;
    unique case (state)
      ST_LOAD: store_we = 1'b1;
      ST_SCAN_EV: idx_adv = !last;
      ST_WRITE: begin
        chan_we = 1'b1;
        unique case (op_q)
          OP_START: begin
            chan_waddr            = slot;
            chan_wdata.position   = POS_W'(addr_m);
            chan_wdata.fraction   = '0;
            chan_wdata.step       = STEP_ROM[pit_q];
            chan_wdata.end_addr   = END_W'(addr_m) + END_W'(len_q);
            chan_wdata.start_tick = tick_q;
            chan_wdata.handle     = hnd_use;
            chan_wdata.sound_id   = sid_q;
            chan_wdata.gain_l     = gain_l;
            chan_wdata.gain_r     = gain_r;
          end
          OP_UPDATE: begin
            chan_waddr        = hit_idx;
            chan_wdata        = rec_hit;
            chan_wdata.step   = STEP_ROM[pit_q];
            chan_wdata.gain_l = gain_l;
            chan_wdata.gain_r = gain_r;
          end
          default: begin
            chan_waddr        = hit_idx;
            chan_wdata        = rec_hit;
            chan_wdata.handle = '0;
          end
        endcase
      end
      ST_MIX_SRD: idx_adv = !active[idx] && !last;
      ST_MIX_ACC: begin
        chan_we             = 1'b1;
        chan_wdata.position = pos_new;
        chan_wdata.fraction = acc_frac[15:0];
        idx_adv             = !last;
      end
      default: ;
    endcase
  end

  // Sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[addr_m] <= data_q;
    end
    store_q <= store_mem[rec_eff.position[AW-1:0]];
  end

  // Channel record memory
  always_ff @(posedge clk) begin
    if (chan_we) begin
      chan_mem[chan_waddr] <= chan_wdata;
    end
    rec_q <= chan_mem[idx];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      written     <= '0;
      active      <= '0;
      next_handle <= '0;
      m_valid     <= 1'b0;
      idx         <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        idx <= '0;
      end else if (idx_adv) begin
        idx <= idx + CH_W'(1);
      end
      if (chan_we) begin
        written[chan_waddr] <= 1'b1;
      end
      // Drop a single-instance copy before the slot is chosen
      if (state == ST_SCAN_END && op_q == OP_START && hit) begin
        active[hit_idx] <= 1'b0;
      end
      if (state == ST_WRITE) begin
        if (op_q == OP_START) begin
          active[slot] <= 1'b1;
          next_handle  <= hnd_use + 16'd1;
        end else if (op_q == OP_STOP) begin
          active[hit_idx] <= 1'b0;
        end
      end
      if (state == ST_MIX_ACC) begin
        active[idx] <= (pos_new < POS_W'(rec_eff.end_addr));
      end
      if (state == ST_DONE && out_free) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Request fields and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q     <= op_t'(s_axis_tuser);
      addr_q   <= s_axis_tdata[15:0];
      data_q   <= s_axis_tdata[23:16];
      len_q    <= s_axis_tdata[39:24];
      vol_q    <= s_axis_tdata[46:40];
      sep_q    <= s_axis_tdata[54:47];
      pit_q    <= s_axis_tdata[62:55];
      sid_q    <= s_axis_tdata[70:63];
      single_q <= s_axis_tdata[71];
      tick_q   <= s_axis_tdata[102:72];
      hnd_q    <= s_axis_tdata[118:103];
      old_tick <= s_axis_tdata[102:72];
      old_idx  <= '0;
      hit      <= 1'b0;
      acc_l    <= '0;
      acc_r    <= '0;
      hout     <= '0;
      playing  <= 1'b0;
    end
    if (state == ST_SCAN_EV) begin
      if (match && !hit) begin
        hit     <= 1'b1;
        hit_idx <= idx;
        rec_hit <= rec_eff;
      end
      if (rec_eff.start_tick < old_tick) begin
        old_tick <= rec_eff.start_tick;
        old_idx  <= idx;
      end
    end
    if (state == ST_SCAN_END && op_q == OP_QUERY) begin
      playing <= hit;
    end
    if (state == ST_GAIN_SQ) begin
      sq_l <= 17'(sep_a * sep_a);
      sq_r <= 17'(sep_b * sep_b);
    end
    if (state == ST_GAIN_MUL) begin
      gain_l <= clamp_gain(vol_q, prod_l[23:16]);
      gain_r <= clamp_gain(vol_q, prod_r[23:16]);
    end
    if (state == ST_WRITE && op_q == OP_START) begin
      hout <= hnd_use;
    end
    if (state == ST_MIX_ACC) begin
      acc_l <= acc_l + ACC_W'(term_l);
      acc_r <= acc_r + ACC_W'(term_r);
    end
  end

  // Saturate the sums
  always_comb begin
    if (acc_l > ACC_W'(SAT_MAX)) begin
      sat_l = SAT_MAX;
    end else if (acc_l < ACC_W'(SAT_MIN)) begin
      sat_l = SAT_MIN;
    end else begin
      sat_l = acc_l[15:0];
    end
    if (acc_r > ACC_W'(SAT_MAX)) begin
      sat_r = SAT_MAX;
    end else if (acc_r < ACC_W'(SAT_MIN)) begin
      sat_r = SAT_MIN;
    end else begin
      sat_r = acc_r[15:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_data <= {7'd0, playing, hout, sat_r, sat_l};
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;

endmodule

// File: sv/pcmmix_checker.sv
// Port-level checks of the PCM mixer core, bound to the top level.
// Depends on multichannel_pcm_sound_mixer_core port names only.
module pcmmix_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [55:0]  m_axis_tdata
);

  // No result straight out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // One request at a time: no back-to-back intake
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // A handle comes alone and is never below the first handle
  a_handle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[47:32] != 16'd0 |->
      m_axis_tdata[47:32] >= 16'd100 && m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[48])
    else $error("bad start result");

endmodule

bind multichannel_pcm_sound_mixer_core pcmmix_checker u_pcmmix_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: bench/tb_top.sv
// Self-checking bench for the multichannel PCM mixer core.
// Drives requests on s_axis, predicts every result and checks m_axis.
// Depends on pcmmix_pkg and multichannel_pcm_sound_mixer_core.
module tb_top;
  import pcmmix_pkg::*;

  localparam int NCH = 8;
  localparam int WDOG_LIMIT = 4000;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [15:0] length;
    logic [6:0]  volume;
    logic [7:0]  separation;
    logic [7:0]  pitch;
    logic [7:0]  sound_id;
    logic        single_instance;
    logic [30:0] game_tick;
    logic [15:0] handle;
  } mix_req_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] hnd;
    logic        playing;
  } mix_res_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [55:0]  m_axis_tdata;

  multichannel_pcm_sound_mixer_core DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Shadow copy of the mixer state
  logic [31:0] pitch_steps [256];
  logic [7:0]  pcm_mem [65536];
  bit          pcm_written [65536];
  bit          ch_on [NCH];
  int unsigned ch_pos [NCH];
  int unsigned ch_frac [NCH];
  int unsigned ch_step [NCH];
  int unsigned ch_end [NCH];
  int unsigned ch_tick [NCH];
  int unsigned ch_hnd [NCH];
  int unsigned ch_sid [NCH];
  int          ch_lg [NCH];
  int          ch_rg [NCH];
  int unsigned handle_ctr;

  mix_res_t    pending_results[$];
  int unsigned recent_handles[$];
  int          mismatches;
  int          burst_left;
  bit          no_gaps;
  bit          rx_always;
  int          rx_run;
  int          idle_cycles;
  int unsigned tick_now;

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Truncating Q62 product
  function automatic logic [63:0] q62_prod(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Build the pitch step table: bisect 2^(1/64), then walk its powers
  task automatic fill_pitch_steps();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] pw;
    logic [63:0] cur;
    lo = 64'd1 << 62;
    hi = lo + (lo >> 6);
    while (hi - lo > 64'd1) begin
      mid = lo + ((hi - lo) >> 1);
      pw = mid;
      repeat (6) pw = q62_prod(pw, pw);
      if (pw <= (64'd2 << 62)) lo = mid;
      else hi = mid;
    end
    cur = 64'd1 << 62;
    for (int r = 0; r < 64; r++) begin
      for (int q = -2; q <= 1; q++) pitch_steps[64 * q + r + 128] = 32'(cur >> (46 - q));
      cur = q62_prod(cur, lo);
    end
  endtask

  function automatic int clamp7(input int g);
    if (g < 0) return 0;
    if (g > 127) return 127;
    return g;
  endfunction

  function automatic void set_pan(input int ch, input int vol, input int sep);
    longint a;
    longint b;
    a = sep + 1;
    b = 256 - sep;
    ch_lg[ch] = clamp7(vol - int'((vol * a * a) >> 16));
    ch_rg[ch] = clamp7(vol - int'((vol * b * b) >> 16));
  endfunction

  function automatic int scaled(input int gain, input int smp);
    return (gain * (smp - 128) * 256) / 127;
  endfunction

  function automatic int sat16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Apply one accepted request to the shadow state and queue its result
  function automatic void mixer_predict(input mix_req_t r);
    mix_res_t res;
    int dl;
    int dr;
    int i;
    int slot;
    int och;
    int unsigned oldest;
    int unsigned acc;
    dl = 0;
    dr = 0;
    res.hnd = '0;
    res.playing = 1'b0;
    case (r.op)
      OP_LOAD: begin
        pcm_mem[r.address] = r.data_byte;
        pcm_written[r.address] = 1'b1;
      end
      OP_START: begin
        if (r.single_instance) begin
          for (i = 0; i < NCH; i++) begin
            if (ch_on[i] && ch_sid[i] == r.sound_id) begin
              ch_on[i] = 1'b0;
              break;
            end
          end
        end
        oldest = r.game_tick;
        och = 0;
        for (i = 0; i < NCH && ch_on[i]; i++) begin
          if (ch_tick[i] < oldest) begin
            oldest = ch_tick[i];
            och = i;
          end
        end
        slot = (i == NCH) ? och : i;
        if (handle_ctr == 0) handle_ctr = 100;
        res.hnd = handle_ctr[15:0];
        handle_ctr = (handle_ctr + 1) & 32'hffff;
        ch_on[slot] = 1'b1;
        ch_pos[slot] = r.address;
        ch_end[slot] = r.address + r.length;
        ch_frac[slot] = 0;
        ch_step[slot] = pitch_steps[r.pitch];
        ch_tick[slot] = r.game_tick;
        ch_hnd[slot] = res.hnd;
        ch_sid[slot] = r.sound_id;
        set_pan(slot, r.volume, r.separation);
        recent_handles.push_back(res.hnd);
        if (recent_handles.size() > 16) void'(recent_handles.pop_front());
      end
      OP_STOP: begin
        for (i = 0; i < NCH; i++) begin
          if (ch_hnd[i] == r.handle) begin
            ch_on[i] = 1'b0;
            ch_hnd[i] = 0;
            break;
          end
        end
      end
      OP_UPDATE: begin
        for (i = 0; i < NCH; i++) begin
          if (ch_hnd[i] == r.handle && ch_on[i]) begin
            set_pan(i, r.volume, r.separation);
            ch_step[i] = pitch_steps[r.pitch];
            break;
          end
        end
      end
      OP_QUERY: begin
        for (i = 0; i < NCH; i++)
          if (ch_hnd[i] == r.handle && ch_on[i]) res.playing = 1'b1;
      end
      OP_MIX: begin
        for (i = 0; i < NCH; i++) begin
          if (ch_on[i]) begin
            dl += scaled(ch_lg[i], pcm_mem[ch_pos[i] & 32'hffff]);
            dr += scaled(ch_rg[i], pcm_mem[ch_pos[i] & 32'hffff]);
            acc = ch_frac[i] + ch_step[i];
            ch_pos[i] += acc >> 16;
            ch_frac[i] = acc & 32'hffff;
            if (ch_pos[i] >= ch_end[i]) ch_on[i] = 1'b0;
          end
        end
        dl = sat16(dl);
        dr = sat16(dr);
      end
      default: ;
    endcase
    res.left = dl[15:0];
    res.right = dr[15:0];
    pending_results.push_back(res);
  endfunction

  // Send one request, honouring the burst pattern, and predict it on acceptance
  task automatic send_req(input mix_req_t r);
    if (!no_gaps) begin
      if (burst_left <= 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
    end
    s_axis_tuser = r.op;
    s_axis_tdata = {1'b0, r.handle, r.game_tick, r.single_instance, r.sound_id, r.pitch,
                    r.separation, r.volume, r.length, r.data_byte, r.address};
    s_axis_tvalid = 1'b1;
    forever begin
      @(posedge clk);
      if (s_axis_tready) break;
    end
    mixer_predict(r);
    @(negedge clk);
  endtask

  function automatic mix_req_t blank_req(input logic [2:0] op);
    mix_req_t r;
    r.op = op;
    r.address = '0;
    r.data_byte = '0;
    r.length = '0;
    r.volume = '0;
    r.separation = '0;
    r.pitch = '0;
    r.sound_id = '0;
    r.single_instance = 1'b0;
    r.game_tick = '0;
    r.handle = '0;
    return r;
  endfunction

  task automatic load_byte(input int a, input int d);
    mix_req_t r;
    r = blank_req(OP_LOAD);
    r.address = a[15:0];
    r.data_byte = d[7:0];
    send_req(r);
  endtask

  task automatic start_sound(input int a, input int len, input int vol, input int sep,
                             input int pit, input int sid, input bit single,
                             input int unsigned tick);
    mix_req_t r;
    r = blank_req(OP_START);
    r.address = a[15:0];
    r.length = len[15:0];
    r.volume = vol[6:0];
    r.separation = sep[7:0];
    r.pitch = pit[7:0];
    r.sound_id = sid[7:0];
    r.single_instance = single;
    r.game_tick = tick[30:0];
    send_req(r);
  endtask

  task automatic handle_op(input logic [2:0] op, input int unsigned h);
    mix_req_t r;
    r = blank_req(op);
    r.handle = h[15:0];
    r.volume = 7'($urandom);
    r.separation = 8'($urandom);
    r.pitch = 8'($urandom);
    send_req(r);
  endtask

  // Mix one tick; first stop any channel about to read a byte never loaded
  task automatic mix_tick();
    for (int i = 0; i < NCH; i++)
      if (ch_on[i] && !pcm_written[ch_pos[i] & 32'hffff]) handle_op(OP_STOP, ch_hnd[i]);
    send_req(blank_req(OP_MIX));
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    @(negedge clk);
  endtask

  // Extremes of sample bytes, and a stretch across the address wrap
  task automatic test_directed_loads();
    load_byte(0, 255);
    load_byte(1, 0);
    load_byte(2, 128);
    load_byte(3, 255);
    load_byte(65535, 0);
  endtask

  // Starts with extreme pan, pitch and volume, wrap, zero length, saturation
  task automatic test_start_mix();
    start_sound(0, 4, 127, 128, 128, 1, 1'b0, 10);
    start_sound(0, 4, 127, 0, 255, 2, 1'b0, 11);
    start_sound(0, 4, 127, 255, 0, 3, 1'b0, 12);
    start_sound(65535, 2, 127, 128, 128, 4, 1'b0, 13);
    start_sound(1, 0, 127, 128, 128, 5, 1'b0, 14);
    start_sound(0, 65535, 0, 128, 200, 6, 1'b0, 15);
    start_sound(0, 3, 127, 128, 64, 7, 1'b0, 16);
    start_sound(0, 3, 127, 128, 128, 8, 1'b0, 17);
    start_sound(3, 1, 90, 30, 128, 1, 1'b1, 9);
    start_sound(3, 1, 90, 30, 128, 99, 1'b0, 2147483647);
    repeat (4) mix_tick();
  endtask

  // Handle lookups with and without a match, and the spare op codes
  task automatic test_handle_ops();
    handle_op(OP_QUERY, 101);
    handle_op(OP_UPDATE, 101);
    handle_op(OP_STOP, 101);
    handle_op(OP_QUERY, 101);
    handle_op(OP_STOP, 65535);
    handle_op(OP_UPDATE, 0);
    handle_op(OP_QUERY, 0);
    send_req(blank_req(OP_SPARE_A));
    send_req(blank_req(OP_SPARE_B));
    mix_tick();
  endtask

  function automatic int pick_addr();
    if ($urandom_range(0, 3) == 0) return $urandom_range(65472, 65535);
    return $urandom_range(0, 191);
  endfunction

  function automatic int unsigned pick_handle();
    if (recent_handles.size() != 0 && $urandom_range(0, 9) < 7)
      return recent_handles[$urandom_range(0, recent_handles.size() - 1)];
    return $urandom_range(0, 65535);
  endfunction

  // Random mix of all requests over a small, well-loaded sample window
  task automatic test_random(input int n_items);
    int sel;
    int len;
    for (int k = 0; k < n_items; k++) begin
      sel = $urandom_range(0, 99);
      if (k % 200 == 100) rx_always = ~rx_always;
      tick_now += $urandom_range(0, 3);
      if (sel < 25) begin
        if ($urandom_range(0, 9) < 8) load_byte(pick_addr(), $urandom_range(0, 255));
        else load_byte($urandom_range(0, 65535), $urandom_range(0, 255));
      end else if (sel < 45) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 48);
        start_sound(pick_addr(), len, $urandom_range(0, 127), $urandom_range(0, 255),
                    ($urandom_range(0, 1) != 0) ? $urandom_range(96, 160)
                                                : $urandom_range(0, 255),
                    ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5)
                                                : $urandom_range(0, 255),
                    1'($urandom),
                    ($urandom_range(0, 19) == 0) ? $urandom_range(0, 32'h7fffffff)
                                                 : tick_now);
      end else if (sel < 53) begin
        handle_op(OP_STOP, pick_handle());
      end else if (sel < 61) begin
        handle_op(OP_UPDATE, pick_handle());
      end else if (sel < 69) begin
        handle_op(OP_QUERY, pick_handle());
      end else if (sel < 97) begin
        mix_tick();
      end else begin
        send_req(blank_req(($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B));
      end
    end
  endtask

  // Requests back to back into an always-ready receiver
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    rx_always = 1'b1;
    for (int k = 0; k < 6; k++) begin
      start_sound(0, 3, 100, 128, 128, 7, 1'b0, tick_now);
      handle_op(OP_QUERY, pick_handle());
      mix_tick();
    end
    no_gaps = 1'b0;
  endtask

  // Receiver stall pattern: runs of ready and not ready of random length
  always @(negedge clk) begin
    if (rst || rx_always) begin
      m_axis_tready = 1'b1;
    end else begin
      if (rx_run <= 0) begin
        m_axis_tready = ~m_axis_tready;
        rx_run = m_axis_tready ? $urandom_range(1, 20) : $urandom_range(1, 8);
      end
      rx_run--;
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    mix_res_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== e.left || m_axis_tdata[31:16] !== e.right ||
            m_axis_tdata[47:32] !== e.hnd || m_axis_tdata[48] !== e.playing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: left %h/%h right %h/%h handle %h/%h playing %b/%b (exp/act)",
                     e.left, m_axis_tdata[15:0], e.right, m_axis_tdata[31:16],
                     e.hnd, m_axis_tdata[47:32], e.playing, m_axis_tdata[48]);
        end
      end
    end
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b1;
    mismatches = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    rx_always = 1'b0;
    rx_run = 0;
    idle_cycles = 0;
    tick_now = 100;
    handle_ctr = 0;
    for (int i = 0; i < NCH; i++) begin
      ch_on[i] = 1'b0;
      ch_pos[i] = 0;
      ch_frac[i] = 0;
      ch_step[i] = 0;
      ch_end[i] = 0;
      ch_tick[i] = 0;
      ch_hnd[i] = 0;
      ch_sid[i] = 0;
      ch_lg[i] = 0;
      ch_rg[i] = 0;
    end
    fill_pitch_steps();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_loads();
    test_start_mix();
    test_handle_ops();
    test_random(1100);
    test_back_to_back();
    s_axis_tvalid = 1'b0;
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
